// File: rtl/core/cfd_pkg.sv
// cfd_pkg: shared types and constants of the callsign frame deframer
// no dependencies; used by the result queue and the top level
`default_nettype none

package cfd_pkg;

    // frame limits
    localparam logic [3:0] MAX_CALLSIGN = 4'd8;
    localparam logic [8:0] MAX_FRAME    = 9'd255;
    localparam logic [8:0] POS_SAT      = 9'd511;

    // result queue geometry (room for two results per transfer plus slack)
    localparam int unsigned RQ_DEPTH = 4;
    localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // configuration register index (byte address bit 3)
    typedef enum logic {
        REG_CALLSIGN_TEXT = 1'b0,
        REG_CALLSIGN_LEN  = 1'b1
    } reg_idx_t;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // summary status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_CALL_MISS = 3'd2,
        ST_LEN_MISS  = 3'd3,
        ST_LONG      = 3'd4
    } status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] function_code;
        logic [7:0] opt_length;
        logic [2:0] status;
        logic       last;
    } result_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

`default_nettype wire

// File: rtl/core/cfd_in_if.sv
// cfd_in_if: input byte channel of the deframer
// no dependencies
`default_nettype none

interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cfd_out_if.sv
// cfd_out_if: result channel of the deframer
// no dependencies
`default_nettype none

interface cfd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] function_code;
    logic [7:0] opt_length;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output kind, output payload_byte, output function_code,
                    output opt_length, output status, output last, input ready);
    modport sink   (input valid, input kind, input payload_byte, input function_code,
                    input opt_length, input status, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/cfd_result_queue.sv
// cfd_result_queue: small register queue, up to two writes and one read per cycle
// depends on cfd_pkg
`default_nettype none

module cfd_result_queue
    import cfd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    output logic         room_for_two,
    output logic         head_valid,
    output result_t      head,
    input  wire logic    pop
);

    result_t               mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg, count_next;
    logic [RQ_PTR_W-1:0]   wr_ptr_plus1;
    logic                  do_pop;

    assign head_valid   = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign do_pop       = pop && head_valid;
    assign wr_ptr_plus1 = wr_ptr_reg + RQ_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RQ_PTR_W'(do_pop);
        count_next  = count_reg + RQ_CNT_W'(push.count) - RQ_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.second;
    end

endmodule

`default_nettype wire

// File: rtl/core/callsign_frame_deframer.sv
// callsign_frame_deframer: top level, frame byte parser with APB configuration
// depends on cfd_pkg, cfd_in_if, cfd_out_if and cfd_result_queue
`default_nettype none

// Byte-wise deframer for received radio frames laid out as callsign, function
// ID byte, then optionally a length byte and that many payload bytes. One byte
// transfer is taken per clock while the queue has room for two results; its
// results are registered in a four-entry result queue. A byte gives no
// result (callsign, function ID, length, dropped payload), one payload result,
// or, on the byte marked frame_end, a summary with function ID, length and a
// status (too short, callsign mismatch, length mismatch, too long, checked in
// that order), possibly preceded by its own payload result. The output moves
// one result per cycle while out_ch.ready is high, so a byte's two results
// leave in turn; the input is held off only while the queue lacks room for two
// results. Payload is dropped once the callsign mismatched and at byte
// positions 255 and up. callsign_text sits at byte address 0 (first character
// in the lowest byte), callsign_len at byte address 8; values above 8 act as 8.
// Configuration is to be written only while no frame is in progress.
module callsign_frame_deframer
    import cfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // apb configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,

    cfd_in_if.sink           in_ch,
    cfd_out_if.source        out_ch
);

    // configuration registers
    logic [63:0] callsign_text_reg;
    logic [3:0]  callsign_len_reg;
    reg_idx_t    reg_idx;
    logic        cfg_write;

    // frame state
    logic [8:0]  pos_reg, pos_next;
    logic        match_reg, match_next;
    logic [7:0]  func_reg, func_next;
    logic [7:0]  len_reg, len_next;

    // datapath
    logic        in_transfer;
    logic [3:0]  cl;
    logic [8:0]  cl9;
    logic [8:0]  pos_inc;
    logic [7:0]  want_char;
    logic        emit_payload;
    result_t     payload_res;
    result_t     summary_res;
    push_t       push;
    logic        room_for_two;
    logic        head_valid;
    result_t     head;

    // ---------------------------------------------------------------
    // configuration port: always ready, write on the access phase
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3]);
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_CALLSIGN_TEXT: prdata = callsign_text_reg;
            REG_CALLSIGN_LEN:  prdata = {60'd0, callsign_len_reg};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            callsign_text_reg <= '0;
            callsign_len_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_CALLSIGN_TEXT: callsign_text_reg <= pwdata;
                REG_CALLSIGN_LEN:  callsign_len_reg  <= pwdata[3:0];
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // byte parser
    // ---------------------------------------------------------------
    assign in_ch.ready = room_for_two;
    assign in_transfer = in_ch.valid && room_for_two;

    // effective callsign length, clamped to the text register size
    assign cl  = (callsign_len_reg > MAX_CALLSIGN) ? MAX_CALLSIGN : callsign_len_reg;
    assign cl9 = {5'd0, cl};

    // expected character for the current position
    assign want_char = callsign_text_reg[{pos_reg[2:0], 3'b000} +: 8];

    // saturating position count
    assign pos_inc = (pos_reg < POS_SAT) ? pos_reg + 9'd1 : pos_reg;

    always_comb
    begin
        match_next   = match_reg;
        func_next    = func_reg;
        len_next     = len_reg;
        emit_payload = 1'b0;

        if (pos_reg < cl9)
        begin
            if (want_char != in_ch.data_byte)
                match_next = 1'b0;
        end
        else if (pos_reg == cl9)
            func_next = in_ch.data_byte;
        else if (pos_reg == cl9 + 9'd1)
            len_next = in_ch.data_byte;
        else if (match_reg && (pos_reg < MAX_FRAME))
            emit_payload = 1'b1;
    end

    // payload result, last unless the summary follows it
    always_comb
    begin
        payload_res               = '0;
        payload_res.kind          = KIND_PAYLOAD;
        payload_res.payload_byte  = in_ch.data_byte;
        payload_res.last          = !in_ch.frame_end;
    end

    // summary built from the already-updated frame state
    always_comb
    begin
        summary_res      = '0;
        summary_res.kind = KIND_SUMMARY;
        summary_res.last = 1'b1;
        if (pos_inc >= cl9 + 9'd1)
            summary_res.function_code = func_next;
        if (pos_inc >= cl9 + 9'd2)
            summary_res.opt_length = len_next;

        if (pos_inc < cl9 + 9'd1)
            summary_res.status = ST_SHORT;
        else if (!match_next)
            summary_res.status = ST_CALL_MISS;
        else if ((pos_inc > cl9 + 9'd1) && ({1'b0, len_next} != pos_inc - cl9 - 9'd2))
            summary_res.status = ST_LEN_MISS;
        else if (pos_inc > MAX_FRAME)
            summary_res.status = ST_LONG;
        else
            summary_res.status = ST_OK;
    end

    // queue write: payload first, then summary
    always_comb
    begin
        push        = '0;
        push.first  = emit_payload ? payload_res : summary_res;
        push.second = summary_res;
        if (in_transfer)
            push.count = 2'(emit_payload) + 2'(in_ch.frame_end);
    end

    // frame state returns to reset after the frame's last byte
    always_comb
    begin
        pos_next = pos_reg;
        if (in_transfer)
        begin
            pos_next = in_ch.frame_end ? 9'd0 : pos_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            match_reg <= 1'b1;
            func_reg  <= '0;
            len_reg   <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (in_transfer)
            begin
                if (in_ch.frame_end)
                begin
                    match_reg <= 1'b1;
                    func_reg  <= '0;
                    len_reg   <= '0;
                end
                else
                begin
                    match_reg <= match_next;
                    func_reg  <= func_next;
                    len_reg   <= len_next;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result queue and output channel
    // ---------------------------------------------------------------
    cfd_result_queue u_result_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room_for_two (room_for_two),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (out_ch.ready)
    );

    assign out_ch.valid         = head_valid;
    assign out_ch.kind          = head.kind;
    assign out_ch.payload_byte  = head.payload_byte;
    assign out_ch.function_code = head.function_code;
    assign out_ch.opt_length    = head.opt_length;
    assign out_ch.status        = head.status;
    assign out_ch.last          = head.last;

endmodule

`default_nettype wire
